FILE: rtl/core/sei_pkg.sv
`default_nettype none

package sei_pkg;

  // Result kinds carried on the output side band.
  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_EXT  = 2'd1;
  localparam logic [1:0] KIND_INF  = 2'd2;

  // Slope direction codes.
  localparam logic [1:0] DIR_FLAT = 2'd0;
  localparam logic [1:0] DIR_RISE = 2'd1;
  localparam logic [1:0] DIR_FALL = 2'd2;

  // Divider operand selection.
  localparam logic DIV_SEL_SLOPE = 1'b0;
  localparam logic DIV_SEL_CURV  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_in;
    logic       div_start;
    logic       div_sel;
    logic       diff;
    logic       save_curv;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic ext_cross;
    logic inf_cross;
    logic dir_nz;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/slope_extremum_inflection_detector_unit.sv
// Finite-difference extremum and inflection detector.
// Input beats carry one (x, y) sample in signed fixed point with FRAC_BITS
// fraction bits. The block keeps the previous point, slope and curvature.
// Output beats report events: the initial direction on the second sample
// (unless the slope is flat), an extremum when the slope changes sign and an
// inflection when the curvature changes sign; tlast marks the final beat
// that one sample causes, and a sample causes at most two beats.
// Sequencing: the first sample after reset only loads the history. Divisions
// run on one shared radix-2 divider that makes one quotient bit a cycle; a
// zero numerator or dx gives its result without the iterations.
// The second sample runs one division. Any later sample runs two dependent
// divisions; the core is ready again once the beats of the sample, if any,
// have been loaded into the output register.
// The input is taken only while the core is idle. One output register holds
// a finished beat, so a stalled receiver does not block the next sample; a
// second beat of the same sample, or the first beat of the next one, waits
// until that register empties. Reset clears all history and any pending beat.
`default_nettype none

module slope_extremum_inflection_detector_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // Fields from bit 0 up: sample_x, sample_y, zero fill to whole bytes.
  input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]          s_axis_tdata_i,
  output logic                                            m_axis_tvalid_o,
  input  wire logic                                       m_axis_tready_i,
  // Fields from bit 0 up: mid_x, mid_y, direction, zero fill to whole bytes.
  output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0]             m_axis_tdata_o,
  // Fields from bit 0 up: event_kind.
  output logic [1:0]                                      m_axis_tuser_o,
  // last_event: the final beat caused by one sample.
  output logic                                            m_axis_tlast_o
);

  localparam int W     = DATA_WIDTH;
  localparam int OUT_W = ((2*DATA_WIDTH+2+7)/8)*8;

  sei_pkg::cmd_t    cmd;
  sei_pkg::status_t status;

  logic [W-1:0] out_mx;
  logic [W-1:0] out_my;
  logic [1:0]   out_dir;

  // The controller sequences the two divisions and the event beats; the
  // datapath holds the history, the divider and the output register.
  sei_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sei_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .x_i        (s_axis_tdata_i[W-1:0]),
    .y_i        (s_axis_tdata_i[2*W-1:W]),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_kind_o (m_axis_tuser_o),
    .out_mx_o   (out_mx),
    .out_my_o   (out_my),
    .out_dir_o  (out_dir),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_W'({out_dir, out_my, out_mx});

endmodule

`default_nettype wire

FILE: rtl/core/sei_div.sv
`default_nettype none

// Restoring radix-2 divider of (nmag << FRAC_BITS) by dmag, one quotient bit a
// cycle, with the signed result saturated to DATA_WIDTH bits.
module sei_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  nneg_i,
  input  wire logic [DATA_WIDTH-1:0] nmag_i,
  input  wire logic                  dneg_i,
  input  wire logic [DATA_WIDTH-1:0] dmag_i,
  output logic                       done_o,
  output logic [DATA_WIDTH-1:0]      quo_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]   QMAX_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0]   QMAX_NEG = {2'b01, {(W-1){1'b0}}};

  logic [CW-1:0] cnt_q;
  logic          fin_q;
  logic          done_q;
  logic [NW-1:0] num_q;
  logic [W-1:0]  rem_q;
  logic [W:0]    q_q;
  logic          big_q;
  logic          neg_q;
  logic [W-1:0]  dmag_q;
  logic [W-1:0]  res_q;

  logic [W:0]    trial;
  logic          ge;
  logic [W:0]    diff;
  logic [W:0]    qneg;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, dmag_q};
  assign diff  = trial - {1'b0, dmag_q};
  assign qneg  = (W+1)'(0) - q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (nmag_i == '0 || dmag_i == '0) begin
          done_q <= 1'b1;
        end else begin
          cnt_q <= CW'(NW);
        end
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= nneg_i ^ dneg_i;
      dmag_q <= dmag_i;
      num_q  <= NW'(nmag_i) << FRAC_BITS;
      rem_q  <= '0;
      q_q    <= '0;
      big_q  <= 1'b0;
      if (nmag_i == '0) begin
        res_q <= '0;
      end else if (dmag_i == '0) begin
        res_q <= nneg_i ? SMIN : SMAX;
      end
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      num_q <= num_q << 1;
      big_q <= big_q | q_q[W];
      q_q   <= {q_q[W-1:0], ge};
    end else if (fin_q) begin
      if (neg_q) begin
        res_q <= (big_q || q_q > QMAX_NEG) ? SMIN : qneg[W-1:0];
      end else begin
        res_q <= (big_q || q_q > QMAX_POS) ? SMAX : q_q[W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/sei_dp.sv
`default_nettype none

module sei_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sei_pkg::cmd_t         cmd_i,
  output sei_pkg::status_t           status_o,
  input  wire logic [DATA_WIDTH-1:0] x_i,
  input  wire logic [DATA_WIDTH-1:0] y_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 out_kind_o,
  output logic [DATA_WIDTH-1:0]      out_mx_o,
  output logic [DATA_WIDTH-1:0]      out_my_o,
  output logic [1:0]                 out_dir_o,
  output logic                       out_last_o
);

  localparam int W = DATA_WIDTH;

  // Signed difference a - b as sign and exact magnitude.
  function automatic logic [W:0] sdiff(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W-1:0] ab;
    logic [W-1:0] bb;
    ab = {~a[W-1], a[W-2:0]};
    bb = {~b[W-1], b[W-2:0]};
    if (ab >= bb) begin
      sdiff = {1'b0, a - b};
    end else begin
      sdiff = {1'b1, b - a};
    end
  endfunction

  function automatic logic is_pos(input logic [W-1:0] v);
    is_pos = !v[W-1] && (v != '0);
  endfunction

  // New value l against old value u.
  function automatic logic crosses(input logic [W-1:0] l, input logic [W-1:0] u);
    crosses = (!is_pos(l) && is_pos(u)) || (u[W-1] && !l[W-1]);
  endfunction

  function automatic logic [W-1:0] midpoint(input logic [W-1:0] a, input logic [W-1:0] b);
    midpoint = {a[W-1], a[W-1:1]} + {b[W-1], b[W-1:1]} + W'(a[0] & b[0]);
  endfunction

  logic [W-1:0] prev_x_q;
  logic [W-1:0] prev_y_q;
  logic [W-1:0] mid_x_q;
  logic [W-1:0] mid_y_q;
  logic         dxn_q;
  logic [W-1:0] dxm_q;
  logic         dyn_q;
  logic [W-1:0] dym_q;
  logic         dsn_q;
  logic [W-1:0] dsm_q;
  logic [W-1:0] prev_slope_q;
  logic [W-1:0] prev_curv_q;
  logic [1:0]   dir_q;

  logic         out_valid_q;
  logic [1:0]   out_kind_q;
  logic [W-1:0] out_mx_q;
  logic [W-1:0] out_my_q;
  logic [1:0]   out_dir_q;
  logic         out_last_q;

  logic [W:0]   dx_w;
  logic [W:0]   dy_w;
  logic [W:0]   ds_w;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic         div_nneg;
  logic [W-1:0] div_nmag;

  assign dx_w = sdiff(x_i, prev_x_q);
  assign dy_w = sdiff(y_i, prev_y_q);
  // During the difference step the divider still holds the new slope.
  assign ds_w = sdiff(div_quo, prev_slope_q);

  assign div_nneg = (cmd_i.div_sel == sei_pkg::DIV_SEL_CURV) ? dsn_q : dyn_q;
  assign div_nmag = (cmd_i.div_sel == sei_pkg::DIV_SEL_CURV) ? dsm_q : dym_q;

  sei_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .nneg_i (div_nneg),
    .nmag_i (div_nmag),
    .dneg_i (dxn_q),
    .dmag_i (dxm_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      prev_x_q <= x_i;
      prev_y_q <= y_i;
      mid_x_q  <= midpoint(x_i, prev_x_q);
      mid_y_q  <= midpoint(y_i, prev_y_q);
      dxn_q    <= dx_w[W];
      dxm_q    <= dx_w[W-1:0];
      dyn_q    <= dy_w[W];
      dym_q    <= dy_w[W-1:0];
    end
    if (cmd_i.diff) begin
      dsn_q        <= ds_w[W];
      dsm_q        <= ds_w[W-1:0];
      prev_slope_q <= div_quo;
      if (is_pos(div_quo)) begin
        dir_q <= sei_pkg::DIR_RISE;
      end else if (div_quo[W-1]) begin
        dir_q <= sei_pkg::DIR_FALL;
      end else begin
        dir_q <= sei_pkg::DIR_FLAT;
      end
    end
    if (cmd_i.save_curv) begin
      prev_curv_q <= div_quo;
    end
  end

  // Output register: holds one beat so the core can move on while it waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_last_q <= cmd_i.out_last;
      out_dir_q  <= dir_q;
      if (cmd_i.out_kind == sei_pkg::KIND_INIT) begin
        out_mx_q <= '0;
        out_my_q <= '0;
      end else begin
        out_mx_q <= mid_x_q;
        out_my_q <= mid_y_q;
      end
    end
  end

  assign status_o.div_done  = div_done;
  assign status_o.ext_cross = crosses(div_quo, prev_slope_q);
  assign status_o.inf_cross = crosses(div_quo, prev_curv_q);
  assign status_o.dir_nz    = div_quo != '0;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_mx_o    = out_mx_q;
  assign out_my_o    = out_my_q;
  assign out_dir_o   = out_dir_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/sei_ctrl.sv
`default_nettype none

module sei_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sei_pkg::status_t  status_i,
  output sei_pkg::cmd_t          cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_WAIT1 = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_WAIT2 = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       have_point_q, have_point_d;
  logic       have_slope_q, have_slope_d;
  logic       have_curv_q, have_curv_d;
  logic       pend_init_q, pend_init_d;
  logic       pend_ext_q, pend_ext_d;
  logic       pend_inf_q, pend_inf_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    have_point_d = have_point_q;
    have_slope_d = have_slope_q;
    have_curv_d  = have_curv_q;
    pend_init_d  = pend_init_q;
    pend_ext_d   = pend_ext_q;
    pend_inf_d   = pend_inf_q;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.cap_in = 1'b1;
          have_point_d = 1'b1;
          if (have_point_q) begin
            state_d = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = sei_pkg::DIV_SEL_SLOPE;
        state_d         = S_WAIT1;
      end
      S_WAIT1: begin
        if (status_i.div_done) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff   = 1'b1;
        have_slope_d = 1'b1;
        if (have_slope_q) begin
          pend_ext_d = status_i.ext_cross;
          state_d    = S_DIV2;
        end else begin
          pend_init_d = status_i.dir_nz;
          state_d     = S_EMIT;
        end
      end
      S_DIV2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = sei_pkg::DIV_SEL_CURV;
        state_d         = S_WAIT2;
      end
      S_WAIT2: begin
        cmd_o.div_sel = sei_pkg::DIV_SEL_CURV;
        if (status_i.div_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.save_curv = 1'b1;
        pend_inf_d      = have_curv_q && status_i.inf_cross;
        have_curv_d     = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        // Results leave in order: initial direction, extremum, inflection.
        if (!pend_init_q && !pend_ext_q && !pend_inf_q) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (pend_init_q) begin
            cmd_o.out_kind = sei_pkg::KIND_INIT;
            cmd_o.out_last = 1'b1;
            pend_init_d    = 1'b0;
            state_d        = S_IDLE;
          end else if (pend_ext_q) begin
            cmd_o.out_kind = sei_pkg::KIND_EXT;
            cmd_o.out_last = !pend_inf_q;
            pend_ext_d     = 1'b0;
            if (!pend_inf_q) begin
              state_d = S_IDLE;
            end
          end else begin
            cmd_o.out_kind = sei_pkg::KIND_INF;
            cmd_o.out_last = 1'b1;
            pend_inf_d     = 1'b0;
            state_d        = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_point_q <= 1'b0;
      have_slope_q <= 1'b0;
      have_curv_q  <= 1'b0;
      pend_init_q  <= 1'b0;
      pend_ext_q   <= 1'b0;
      pend_inf_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      have_point_q <= have_point_d;
      have_slope_q <= have_slope_d;
      have_curv_q  <= have_curv_d;
      pend_init_q  <= pend_init_d;
      pend_ext_q   <= pend_ext_d;
      pend_inf_q   <= pend_inf_d;
    end
  end

endmodule

`default_nettype wire
